@@ rtl/pdim_pkg.sv @@
// pdim_pkg: shared types and constants of the phase-control dimmer
// event kinds, phase codes, configuration indexes and the request struct
// no dependencies
`default_nettype none

package pdim_pkg;

    // event kind carried by one request
    typedef enum logic [1:0] {
        KIND_EDGE = 2'd0,
        KIND_TICK = 2'd1,
        KIND_LOSS = 2'd2,
        KIND_LOAD = 2'd3
    } t_kind;

    // phase machine codes
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_START  = 3'd1,
        PH_LOADED = 3'd2,
        PH_AWAIT  = 3'd3,
        PH_FIRING = 3'd4
    } t_phase;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_START = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_STOP  = 1'd1;

    // field widths
    localparam int SLOT_W   = 8;
    localparam int THR_W    = 7;
    localparam int CH_W     = 3;
    localparam int LEVEL_W  = 8;
    localparam int PERIOD_W = 16;
    localparam int MASK_W   = 8;

    // slot counter and slot window values after reset
    localparam logic [SLOT_W-1:0] SLOT_START_INIT = 8'd0;
    localparam logic [SLOT_W-1:0] SLOT_STOP_INIT  = 8'd255;

    // one registered request
    typedef struct packed {
        t_kind                kind;
        logic [CH_W-1:0]      channel;
        logic [LEVEL_W-1:0]   level;
        logic [PERIOD_W-1:0]  period;
    } t_event;

endpackage

`default_nettype wire

@@ rtl/pdim_in_stage.sv @@
// pdim_in_stage: input register of the dimmer sequencer
// holds one accepted request until the core takes it; uses pdim_pkg
`default_nettype none

module pdim_in_stage (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [1:0]                     i_kind,
    input  wire logic [pdim_pkg::CH_W-1:0]      i_channel,
    input  wire logic [pdim_pkg::LEVEL_W-1:0]   i_level,
    input  wire logic [pdim_pkg::PERIOD_W-1:0]  i_measured_period,
    input  wire logic                           i_ready,
    output logic                                o_ev_valid,
    output pdim_pkg::t_event                    o_ev
);

    logic             r_valid;
    logic             n_valid;
    pdim_pkg::t_event r_ev;
    logic             w_take;

    // hold while the core cannot take the stored request
    assign o_stall = r_valid && !i_ready;
    assign w_take  = i_valid && !o_stall;

    always_comb begin
        if (w_take) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // request payload
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_ev.kind    <= pdim_pkg::t_kind'(i_kind);
            r_ev.channel <= i_channel;
            r_ev.level   <= i_level;
            r_ev.period  <= i_measured_period;
        end
    end

    assign o_ev_valid = r_valid;
    assign o_ev       = r_ev;

endmodule

`default_nettype wire

@@ rtl/pdim_core.sv @@
// pdim_core: phase machine, slot counter, thresholds, gates and result register
// takes one request per cycle from pdim_in_stage while the result side does not stall; uses pdim_pkg
`default_nettype none

module pdim_core #(
    parameter int CHANNELS = 8
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [pdim_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [pdim_pkg::SLOT_W-1:0]           i_cfg_data,
    input  wire logic                                  i_ev_valid,
    input  wire pdim_pkg::t_event                      i_ev,
    output logic                                       o_ready,
    output logic                                       o_valid,
    input  wire logic                                  i_stall,
    output logic [pdim_pkg::MASK_W-1:0]                o_gate_mask,
    output logic                                       o_wait_falling,
    output logic                                       o_firing_running,
    output logic                                       o_measuring_running,
    output logic                                       o_period_load,
    output logic [pdim_pkg::PERIOD_W-1:0]              o_period_value,
    output logic [2:0]                                 o_phase
);

    // gate vector is at least as wide as the mask port
    localparam int GW = (CHANNELS > pdim_pkg::MASK_W) ? CHANNELS : pdim_pkg::MASK_W;

    // configuration
    logic [pdim_pkg::SLOT_W-1:0]   r_slot_start;
    logic [pdim_pkg::SLOT_W-1:0]   r_slot_stop;

    // sequencer state
    pdim_pkg::t_phase              r_phase;
    pdim_pkg::t_phase              n_phase;
    logic [pdim_pkg::SLOT_W-1:0]   r_slot;
    logic [pdim_pkg::SLOT_W-1:0]   n_slot;
    logic [pdim_pkg::THR_W-1:0]    r_thr [CHANNELS];
    logic [GW-1:0]                 r_gates;
    logic [GW-1:0]                 n_gates;
    logic                          r_firing;
    logic                          n_firing;
    logic                          r_measure;
    logic                          n_measure;
    logic                          r_falling;
    logic                          n_falling;
    logic                          n_load;
    logic [pdim_pkg::PERIOD_W-1:0] n_value;

    // result register
    logic                          r_out_valid;
    logic                          n_out_valid;
    logic [pdim_pkg::MASK_W-1:0]   r_out_mask;
    logic                          r_out_falling;
    logic                          r_out_firing;
    logic                          r_out_measure;
    logic                          r_out_load;
    logic [pdim_pkg::PERIOD_W-1:0] r_out_value;
    logic [2:0]                    r_out_phase;

    logic                          w_take;
    logic [GW-1:0]                 w_fire;
    logic                          w_edge;

    assign o_ready = !(r_out_valid && i_stall);
    assign w_take  = i_ev_valid && o_ready;
    assign w_edge  = (i_ev.kind == pdim_pkg::KIND_EDGE);

    // per-channel threshold compare against the current slot
    always_comb begin
        w_fire = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            w_fire[i] = ({1'b0, r_thr[i]} < r_slot);
        end
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (i_ev.kind)
            pdim_pkg::KIND_EDGE: begin
                unique case (r_phase)
                    pdim_pkg::PH_START:  n_phase = pdim_pkg::PH_LOADED;
                    pdim_pkg::PH_LOADED,
                    pdim_pkg::PH_AWAIT:  n_phase = pdim_pkg::PH_FIRING;
                    pdim_pkg::PH_FIRING: n_phase = pdim_pkg::PH_AWAIT;
                    default:             n_phase = pdim_pkg::PH_START;
                endcase
            end
            pdim_pkg::KIND_LOSS: n_phase = pdim_pkg::PH_IDLE;
            default:             n_phase = r_phase;
        endcase
    end

    // next values of gates, slot counter and timer controls
    always_comb begin
        n_gates   = r_gates;
        n_slot    = r_slot;
        n_firing  = r_firing;
        n_measure = r_measure;
        n_falling = r_falling;
        n_load    = 1'b0;
        n_value   = '0;
        unique case (i_ev.kind)
            pdim_pkg::KIND_EDGE: begin
                unique case (r_phase)
                    pdim_pkg::PH_START: begin
                        n_falling = 1'b0;
                        n_firing  = 1'b0;
                        n_measure = 1'b1;
                    end
                    pdim_pkg::PH_LOADED,
                    pdim_pkg::PH_AWAIT: begin
                        n_gates   = '0;
                        n_falling = 1'b1;
                        n_firing  = 1'b0;
                        n_measure = 1'b0;
                        n_load    = 1'b1;
                        n_value   = i_ev.period;
                        n_slot    = r_slot_start;
                    end
                    pdim_pkg::PH_FIRING: begin
                        n_falling = 1'b0;
                        n_firing  = 1'b1;
                        n_measure = 1'b1;
                    end
                    default: begin
                        n_gates   = '0;
                        n_falling = 1'b1;
                        n_firing  = 1'b0;
                        n_measure = 1'b0;
                    end
                endcase
            end
            pdim_pkg::KIND_TICK: begin
                if (r_slot < r_slot_stop) begin
                    n_gates = r_gates | w_fire;
                    n_slot  = r_slot + 1'b1;
                end
            end
            pdim_pkg::KIND_LOSS: begin
                n_gates   = '0;
                n_falling = 1'b0;
                n_firing  = 1'b0;
                n_measure = 1'b0;
            end
            default: begin
                n_gates = r_gates;
            end
        endcase
    end

    // result valid: set on a taken request, cleared once delivered
    always_comb begin
        if (w_take) begin
            n_out_valid = 1'b1;
        end else if (i_stall) begin
            n_out_valid = r_out_valid;
        end else begin
            n_out_valid = 1'b0;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_start <= pdim_pkg::SLOT_START_INIT;
            r_slot_stop  <= pdim_pkg::SLOT_STOP_INIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pdim_pkg::CFG_SLOT_START: r_slot_start <= i_cfg_data;
                pdim_pkg::CFG_SLOT_STOP:  r_slot_stop  <= i_cfg_data;
                default:                  r_slot_stop  <= r_slot_stop;
            endcase
        end
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= pdim_pkg::PH_IDLE;
            r_slot      <= pdim_pkg::SLOT_START_INIT;
            r_gates     <= '0;
            r_firing    <= 1'b0;
            r_measure   <= 1'b0;
            r_falling   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (w_take) begin
                r_phase   <= n_phase;
                r_slot    <= n_slot;
                r_gates   <= n_gates;
                r_firing  <= n_firing;
                r_measure <= n_measure;
                r_falling <= n_falling;
            end
        end
    end

    // channel thresholds, stored as the level halved
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_thr[i] <= '0;
            end
        end else if (w_take && i_ev.kind == pdim_pkg::KIND_LOAD) begin
            for (int i = 0; i < CHANNELS; i++) begin
                if ({29'd0, i_ev.channel} == 32'(i)) begin
                    r_thr[i] <= i_ev.level[pdim_pkg::LEVEL_W-1:1];
                end
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_mask    <= n_gates[pdim_pkg::MASK_W-1:0];
            r_out_falling <= n_falling;
            r_out_firing  <= n_firing;
            r_out_measure <= n_measure;
            r_out_load    <= n_load && w_edge;
            r_out_value   <= n_value;
            r_out_phase   <= n_phase;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_gate_mask         = r_out_mask;
    assign o_wait_falling      = r_out_falling;
    assign o_firing_running    = r_out_firing;
    assign o_measuring_running = r_out_measure;
    assign o_period_load       = r_out_load;
    assign o_period_value      = r_out_value;
    assign o_phase             = r_out_phase;

endmodule

`default_nettype wire

@@ rtl/phase_control_dimmer.sv @@
// phase_control_dimmer: mains phase-control dimmer sequencer, top level
// an accepted request passes the input register, then the result register, to the outputs
// throughput: one request per cycle while i_stall does not hold the result, set by the input and result registers
// reset (synchronous, active low) clears phase, gates, timer controls,
// slot counter, thresholds and configuration; no clearing pass is needed
// uses pdim_pkg, pdim_in_stage and pdim_core
`default_nettype none

module phase_control_dimmer #(
    parameter int CHANNELS = 8
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [pdim_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [pdim_pkg::SLOT_W-1:0]    i_cfg_data,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [1:0]                     i_kind,
    input  wire logic [pdim_pkg::CH_W-1:0]      i_channel,
    input  wire logic [pdim_pkg::LEVEL_W-1:0]   i_level,
    input  wire logic [pdim_pkg::PERIOD_W-1:0]  i_measured_period,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic [pdim_pkg::MASK_W-1:0]         o_gate_mask,
    output logic                                o_wait_falling,
    output logic                                o_firing_running,
    output logic                                o_measuring_running,
    output logic                                o_period_load,
    output logic [pdim_pkg::PERIOD_W-1:0]       o_period_value,
    output logic [2:0]                          o_phase
);

    logic             w_ev_valid;
    logic             w_ready;
    pdim_pkg::t_event w_ev;

    // input register
    pdim_in_stage u_in_stage (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_kind            (i_kind),
        .i_channel         (i_channel),
        .i_level           (i_level),
        .i_measured_period (i_measured_period),
        .i_ready           (w_ready),
        .o_ev_valid        (w_ev_valid),
        .o_ev              (w_ev)
    );

    // sequencer and result register
    pdim_core #(
        .CHANNELS (CHANNELS)
    ) u_core (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_ev_valid          (w_ev_valid),
        .i_ev                (w_ev),
        .o_ready             (w_ready),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_gate_mask         (o_gate_mask),
        .o_wait_falling      (o_wait_falling),
        .o_firing_running    (o_firing_running),
        .o_measuring_running (o_measuring_running),
        .o_period_load       (o_period_load),
        .o_period_value      (o_period_value),
        .o_phase             (o_phase)
    );

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// testbench for phase_control_dimmer: directed events, then random mains sequences
// a scoreboard class predicts each result; plain tasks drive requests and registers
// depends on pdim_pkg and phase_control_dimmer
`timescale 1ns / 1ps

module testbench;
    import pdim_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int SEGMENTS       = 6;
    localparam int ITEMS_PER_SEG  = 220;

    // one result as seen on the output ports
    typedef struct packed {
        logic [MASK_W-1:0]   gate_mask;
        logic                wait_falling;
        logic                firing_running;
        logic                measuring_running;
        logic                period_load;
        logic [PERIOD_W-1:0] period_value;
        logic [2:0]          phase;
    } t_dimmer_out;

    // predicts the dimmer state per request and checks results in order
    class dimmer_tracker;
        t_phase              phase;
        logic [SLOT_W-1:0]   slot;
        logic [THR_W-1:0]    thr [8];
        logic [MASK_W-1:0]   gates;
        logic                firing;
        logic                measuring;
        logic                falling;
        logic [SLOT_W-1:0]   slot_start;
        logic [SLOT_W-1:0]   slot_stop;
        t_dimmer_out         expected_outputs [$];
        int                  mismatches;

        function new();
            slot_start = SLOT_START_INIT;
            slot_stop  = SLOT_STOP_INIT;
            phase      = PH_IDLE;
            slot       = SLOT_START_INIT;
            foreach (thr[i]) thr[i] = '0;
            gates      = '0;
            firing     = 1'b0;
            measuring  = 1'b0;
            falling    = 1'b0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [SLOT_W-1:0] data);
            case (idx)
                CFG_SLOT_START: slot_start = data;
                CFG_SLOT_STOP:  slot_stop = data;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_outputs.size();
        endfunction

        // advance the predicted state by one accepted request
        function void note_event(t_kind kind, logic [CH_W-1:0] ch, logic [LEVEL_W-1:0] level,
                                 logic [PERIOD_W-1:0] period);
            t_dimmer_out res;
            res = '0;
            case (kind)
                KIND_EDGE: begin
                    case (phase)
                        PH_START: begin
                            falling   = 1'b0;
                            firing    = 1'b0;
                            measuring = 1'b1;
                            phase     = PH_LOADED;
                        end
                        PH_LOADED, PH_AWAIT: begin
                            gates            = '0;
                            falling          = 1'b1;
                            firing           = 1'b0;
                            measuring        = 1'b0;
                            res.period_load  = 1'b1;
                            res.period_value = period;
                            slot             = slot_start;
                            phase            = PH_FIRING;
                        end
                        PH_FIRING: begin
                            falling   = 1'b0;
                            firing    = 1'b1;
                            measuring = 1'b1;
                            phase     = PH_AWAIT;
                        end
                        default: begin
                            gates     = '0;
                            falling   = 1'b1;
                            measuring = 1'b0;
                            firing    = 1'b0;
                            phase     = PH_START;
                        end
                    endcase
                end
                KIND_TICK: begin
                    // gates latch on for thresholds below the slot, until the stop slot
                    if (slot < slot_stop) begin
                        for (int i = 0; i < 8; i++) begin
                            if (thr[i] < slot) gates[i] = 1'b1;
                        end
                        slot = slot + 1'b1;
                    end
                end
                KIND_LOSS: begin
                    gates     = '0;
                    falling   = 1'b0;
                    measuring = 1'b0;
                    firing    = 1'b0;
                    phase     = PH_IDLE;
                end
                default: thr[ch] = level[LEVEL_W-1:1];
            endcase
            res.gate_mask         = gates;
            res.wait_falling      = falling;
            res.firing_running    = firing;
            res.measuring_running = measuring;
            res.phase             = phase;
            expected_outputs.push_back(res);
        endfunction

        function void flag(string what, logic [PERIOD_W-1:0] exp, logic [PERIOD_W-1:0] got);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, exp, got);
        endfunction

        function void check_outputs(t_dimmer_out got);
            t_dimmer_out exp;
            if (expected_outputs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with no pending request, gate_mask %0h phase %0d",
                             $time, got.gate_mask, got.phase);
                return;
            end
            exp = expected_outputs.pop_front();
            if (got.gate_mask !== exp.gate_mask)
                flag("gate_mask", PERIOD_W'(exp.gate_mask), PERIOD_W'(got.gate_mask));
            if (got.wait_falling !== exp.wait_falling)
                flag("wait_falling", PERIOD_W'(exp.wait_falling),
                     PERIOD_W'(got.wait_falling));
            if (got.firing_running !== exp.firing_running)
                flag("firing_running", PERIOD_W'(exp.firing_running),
                     PERIOD_W'(got.firing_running));
            if (got.measuring_running !== exp.measuring_running)
                flag("measuring_running", PERIOD_W'(exp.measuring_running),
                     PERIOD_W'(got.measuring_running));
            if (got.period_load !== exp.period_load)
                flag("period_load", PERIOD_W'(exp.period_load), PERIOD_W'(got.period_load));
            if (got.period_value !== exp.period_value)
                flag("period_value", exp.period_value, got.period_value);
            if (got.phase !== exp.phase)
                flag("phase", PERIOD_W'(exp.phase), PERIOD_W'(got.phase));
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [SLOT_W-1:0]    i_cfg_data = '0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [1:0]           i_kind = '0;
    logic [CH_W-1:0]      i_channel = '0;
    logic [LEVEL_W-1:0]   i_level = '0;
    logic [PERIOD_W-1:0]  i_measured_period = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [MASK_W-1:0]    o_gate_mask;
    logic                 o_wait_falling;
    logic                 o_firing_running;
    logic                 o_measuring_running;
    logic                 o_period_load;
    logic [PERIOD_W-1:0]  o_period_value;
    logic [2:0]           o_phase;

    dimmer_tracker tracker;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    int            hold_off_requests = 0;
    logic [SLOT_W-1:0] seg_slot_start [SEGMENTS] = '{8'd0, 8'd255, 8'd100, 8'd0, 8'd0, 8'd200};
    logic [SLOT_W-1:0] seg_slot_stop [SEGMENTS] = '{8'd255, 8'd0, 8'd180, 8'd40, 8'd0, 8'd255};

    phase_control_dimmer DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_kind              (i_kind),
        .i_channel           (i_channel),
        .i_level             (i_level),
        .i_measured_period   (i_measured_period),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_gate_mask         (o_gate_mask),
        .o_wait_falling      (o_wait_falling),
        .o_firing_running    (o_firing_running),
        .o_measuring_running (o_measuring_running),
        .o_period_load       (o_period_load),
        .o_period_value      (o_period_value),
        .o_phase             (o_phase)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // result side: random stalls, or a long hold-off when one is requested
    initial begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(negedge i_clk);
            if (hold_seen != hold_off_requests) begin
                hold_seen = hold_off_requests;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            end
        end
    end

    // check every accepted result
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            tracker.check_outputs({o_gate_mask, o_wait_falling, o_firing_running,
                                   o_measuring_running, o_period_load, o_period_value,
                                   o_phase});
    end

    // end the run when nothing moves for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("testbench NOT OK");
        $finish;
    end

    // offer one request, with random idle cycles first, and wait until taken
    task automatic send_request(input t_kind kind, input logic [CH_W-1:0] ch,
                                input logic [LEVEL_W-1:0] level,
                                input logic [PERIOD_W-1:0] period);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid           <= 1'b1;
        i_kind            <= kind;
        i_channel         <= ch;
        i_level           <= level;
        i_measured_period <= period;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        tracker.note_event(kind, ch, level, period);
    endtask

    task automatic send_random(input t_kind kind);
        logic [LEVEL_W-1:0] lvl;
        lvl = LEVEL_W'($urandom_range(0, 255));
        if ($urandom_range(0, 15) == 0) lvl = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        send_request(kind, CH_W'($urandom_range(0, 7)), lvl,
                     PERIOD_W'($urandom_range(0, 65535)));
    endtask

    // mostly mains half cycles (crossing plus a run of slot ticks), some loads and losses
    task automatic run_random(input int budget);
        int sent;
        int burst;
        int r;
        sent = 0;
        while (sent < budget) begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
                send_random(KIND_LOSS);
                sent++;
            end else if (r < 15) begin
                send_random(KIND_LOAD);
                sent++;
            end else begin
                send_random(KIND_EDGE);
                sent++;
                burst = ($urandom_range(0, 24) == 0) ? $urandom_range(100, 200)
                                                     : $urandom_range(0, 40);
                repeat (burst) begin
                    if ($urandom_range(0, 29) == 0) send_random(KIND_LOAD);
                    else send_random(KIND_TICK);
                    sent++;
                end
            end
        end
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [SLOT_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        tracker.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_until_quiet;
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // main sequence
    initial begin
        int seg;
        tracker = new();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: short slot window, loads at the level extremes, every phase
        write_register(CFG_SLOT_START, 8'd0);
        write_register(CFG_SLOT_STOP, 8'd3);
        send_idle_pct  = 20;
        recv_stall_pct = 82;
        // tick while idle with the firing timer off
        send_request(KIND_TICK, 3'd0, 8'd0, 16'd0);
        send_request(KIND_LOAD, 3'd0, 8'h00, 16'h0000);
        send_request(KIND_LOAD, 3'd7, 8'hFF, 16'hFFFF);
        send_request(KIND_LOAD, 3'd1, 8'h01, 16'h0000);
        send_request(KIND_LOAD, 3'd2, 8'h03, 16'h0000);
        send_request(KIND_TICK, 3'd0, 8'd0, 16'd0);
        // idle to start to loaded to firing, with a full period handed over
        send_request(KIND_EDGE, 3'd0, 8'd0, 16'h0000);
        send_request(KIND_EDGE, 3'd0, 8'd0, 16'h0000);
        send_request(KIND_EDGE, 3'd0, 8'd0, 16'hFFFF);
        // ticks run up to the stop slot and then hold
        repeat (5) send_request(KIND_TICK, 3'd0, 8'd0, 16'd0);
        send_request(KIND_EDGE, 3'd0, 8'd0, 16'h0000);
        send_request(KIND_EDGE, 3'd0, 8'd0, 16'h0000);
        // mains loss in the firing, start, loaded and await phases
        send_request(KIND_LOSS, 3'd0, 8'd0, 16'd0);
        send_request(KIND_EDGE, 3'd0, 8'd0, 16'd0);
        send_request(KIND_LOSS, 3'd0, 8'd0, 16'd0);
        send_request(KIND_EDGE, 3'd0, 8'd0, 16'd0);
        send_request(KIND_EDGE, 3'd0, 8'd0, 16'd0);
        send_request(KIND_LOSS, 3'd0, 8'd0, 16'd0);
        repeat (3) send_request(KIND_EDGE, 3'd0, 8'd0, 16'h1234);
        send_request(KIND_EDGE, 3'd0, 8'd0, 16'd0);
        send_request(KIND_LOSS, 3'd0, 8'd0, 16'd0);

        // random segments, each with its own slot window; each pair of segments shares an idling mode
        for (seg = 0; seg < SEGMENTS; seg++) begin
            wait_until_quiet();
            if (seg == 4) begin
                seg_slot_start[seg] = SLOT_W'($urandom_range(0, 255));
                seg_slot_stop[seg]  = SLOT_W'($urandom_range(0, 255));
            end
            write_register(CFG_SLOT_START, seg_slot_start[seg]);
            write_register(CFG_SLOT_STOP, seg_slot_stop[seg]);
            case (seg / 2)
                0: begin
                    send_idle_pct  = 20;
                    recv_stall_pct = 82;
                end
                1: begin
                    send_idle_pct  = 82;
                    recv_stall_pct = 20;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            // long hold-off on the result side while requests keep coming
            if (seg == 4) hold_off_requests++;
            run_random(ITEMS_PER_SEG);
        end

        wait_until_quiet();
        if (tracker.mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
